FILE: sv/fbsp_pkg.sv
// Shared types, constants and helpers for the flow batch size policy block.
// No dependencies; imported by the interfaces, the rate divider and the top level.
package fbsp_pkg;

    // ticks per second used to scale the packet rate
    localparam int TICKS_PER_SECOND = 100;
    localparam int TPS_W            = $clog2(TICKS_PER_SECOND + 1);
    localparam int WORD_W           = 32;
    localparam int NUM_W            = WORD_W + TPS_W;
    localparam int CNT_W            = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(WORD_W - 1);

    localparam int SIZE_W   = 8;
    localparam int PDATA_W  = 64;
    localparam int PADDR_W  = 6;

    // register map, index = paddr[5:3]
    localparam logic [2:0] REG_FIXED_COUNT     = 3'd0;
    localparam logic [2:0] REG_FLEX_COUNT      = 3'd1;
    localparam logic [2:0] REG_BATCH_SIZES     = 3'd2;
    localparam logic [2:0] REG_RATE_STEPS_LOW  = 3'd3;
    localparam logic [2:0] REG_RATE_STEPS_HIGH = 3'd4;
    localparam logic [2:0] REG_PHASE_THRESHOLD = 3'd5;
    localparam logic [2:0] REG_PHASE_INTERVALS = 3'd6;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_FIXED = 2'd1,
        MODE_FLEX  = 2'd2
    } mode_t;

    // divider request / response
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] pkts;
        logic [WORD_W-1:0] ticks;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quot;
    } div_rsp_t;

    // wrap-safe "a is after b"
    function automatic logic is_after(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[WORD_W-1];
    endfunction

endpackage

FILE: sv/fbsp_if.sv
// Valid/ready channel interfaces for the flow batch size policy block.
// Depends on fbsp_pkg for field widths.
interface fbsp_item_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [fbsp_pkg::WORD_W-1:0] now;

    modport source (output valid, kind, now, input ready);
    modport sink   (input valid, kind, now, output ready);
endinterface

interface fbsp_result_if;
    logic                        valid;
    logic                        ready;
    logic [fbsp_pkg::SIZE_W-1:0] batch_size;
    logic [1:0]                  mode;
    logic [fbsp_pkg::WORD_W-1:0] rate;

    modport source (output valid, batch_size, mode, rate, input ready);
    modport sink   (input valid, batch_size, mode, rate, output ready);
endinterface

FILE: sv/fbsp_div.sv
// Iterative rate divider: (pkts * TICKS_PER_SECOND) / ticks, saturating to all ones.
// One quotient bit per cycle. Depends on fbsp_pkg.
module fbsp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  fbsp_pkg::div_req_t req,
    output fbsp_pkg::div_rsp_t rsp
);
    import fbsp_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_CHECK = 3'b010,
        D_ITER  = 3'b100
    } dstate_t;

    dstate_t            state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [WORD_W-1:0]  den_reg, den_next;
    logic [WORD_W-1:0]  rem_reg, rem_next;
    logic [WORD_W-1:0]  quo_reg, quo_next;
    logic [WORD_W-1:0]  quot_reg, quot_next;

    logic [WORD_W:0]    trial;
    logic [WORD_W:0]    diff;
    logic               ge;
    logic [WORD_W-1:0]  num_hi;

    assign num_hi = WORD_W'(num_reg[NUM_W-1:WORD_W]);
    assign trial  = {rem_reg, quo_reg[WORD_W-1]};
    assign diff   = trial - {1'b0, den_reg};
    assign ge     = (trial >= {1'b0, den_reg});

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        quot_next  = quot_reg;
        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    num_next   = NUM_W'(req.pkts) * NUM_W'(TICKS_PER_SECOND);
                    den_next   = req.ticks;
                    state_next = D_CHECK;
                end
            end
            D_CHECK:
            begin
                // zero divisor or quotient wider than 32 bits saturates
                if (den_reg == '0 || num_hi >= den_reg)
                begin
                    quot_next  = '1;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    rem_next   = num_hi;
                    quo_next   = num_reg[WORD_W-1:0];
                    cnt_next   = '0;
                    state_next = D_ITER;
                end
            end
            D_ITER:
            begin
                rem_next = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ITER_LAST)
                begin
                    quot_next  = {quo_reg[WORD_W-2:0], ge};
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

FILE: sv/flow_batch_size_policy.sv
// Flow batch size policy: one flow's receive batching decision per request.
// To result valid: a start goes straight to the output; a flexible packet with no update
// is only evaluated; a packet that runs the policy adds the policy step, the ladder step
// when flexible and up to two rate divisions (cut short on saturation) in the shared
// divider. One request in flight; the next is accepted the cycle after the result loads
// the output register. Reset (rst_n, async low) clears config, flow state and out valid.
module flow_batch_size_policy (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fbsp_pkg::PADDR_W-1:0]   paddr,
    input  logic [fbsp_pkg::PDATA_W-1:0]   pwdata,
    output logic [fbsp_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    fbsp_item_if.sink                      item,
    fbsp_result_if.source                  result
);
    import fbsp_pkg::*;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_EVAL      = 7'b0000010,
        S_MEAS_WAIT = 7'b0000100,
        S_POLICY    = 7'b0001000,
        S_FLEX_WAIT = 7'b0010000,
        S_LADDER    = 7'b0100000,
        S_EMIT      = 7'b1000000
    } state_t;

    // ---------------- configuration registers ----------------
    logic [WORD_W-1:0]   fixed_count_reg;
    logic [WORD_W-1:0]   flex_count_reg;
    logic [6*SIZE_W-1:0] batch_sizes_reg;
    logic [63:0]         rate_steps_low_reg;
    logic [63:0]         rate_steps_high_reg;
    logic [WORD_W-1:0]   phase_threshold_reg;
    logic [63:0]         phase_intervals_reg;

    logic                cfg_write;
    logic [2:0]          cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fixed_count_reg     <= '0;
            flex_count_reg      <= '0;
            batch_sizes_reg     <= '0;
            rate_steps_low_reg  <= '0;
            rate_steps_high_reg <= '0;
            phase_threshold_reg <= '0;
            phase_intervals_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FIXED_COUNT:     fixed_count_reg     <= pwdata[WORD_W-1:0];
                REG_FLEX_COUNT:      flex_count_reg      <= pwdata[WORD_W-1:0];
                REG_BATCH_SIZES:     batch_sizes_reg     <= pwdata[6*SIZE_W-1:0];
                REG_RATE_STEPS_LOW:  rate_steps_low_reg  <= pwdata;
                REG_RATE_STEPS_HIGH: rate_steps_high_reg <= pwdata;
                REG_PHASE_THRESHOLD: phase_threshold_reg <= pwdata[WORD_W-1:0];
                REG_PHASE_INTERVALS: phase_intervals_reg <= pwdata;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_FIXED_COUNT:     prdata = PDATA_W'(fixed_count_reg);
            REG_FLEX_COUNT:      prdata = PDATA_W'(flex_count_reg);
            REG_BATCH_SIZES:     prdata = PDATA_W'(batch_sizes_reg);
            REG_RATE_STEPS_LOW:  prdata = rate_steps_low_reg;
            REG_RATE_STEPS_HIGH: prdata = rate_steps_high_reg;
            REG_PHASE_THRESHOLD: prdata = PDATA_W'(phase_threshold_reg);
            REG_PHASE_INTERVALS: prdata = phase_intervals_reg;
            default:             prdata = '0;
        endcase
    end

    // ---------------- flow state ----------------
    state_t             state_reg, state_next;
    logic [WORD_W-1:0]  pkt_total_reg, pkt_total_next;
    logic [WORD_W-1:0]  tot_capt_reg, tot_capt_next;     // total at last capture
    logic [WORD_W-1:0]  last_tick_reg, last_tick_next;
    logic [WORD_W-1:0]  capt_tick_reg, capt_tick_next;
    logic [WORD_W-1:0]  created_tick_reg, created_tick_next;
    logic [WORD_W-1:0]  interval_reg, interval_next;
    logic [WORD_W-1:0]  stored_rate_reg, stored_rate_next;
    mode_t              mode_reg, mode_next;
    logic [SIZE_W-1:0]  size_reg, size_next;

    // rate fed to the size ladder for this request
    logic [WORD_W-1:0]  ladder_rate_reg, ladder_rate_next;

    // output holding register
    logic               out_valid_reg, out_valid_next;
    logic [SIZE_W-1:0]  out_size_reg, out_size_next;
    mode_t              out_mode_reg, out_mode_next;
    logic [WORD_W-1:0]  out_rate_reg, out_rate_next;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    fbsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- size ladder ----------------
    logic [SIZE_W-1:0]  ladder_pick;
    logic [SIZE_W-1:0]  ladder_size;
    logic [SIZE_W-1:0]  size_floor;

    assign size_floor = batch_sizes_reg[5*SIZE_W +: SIZE_W];

    always_comb
    begin
        if (ladder_rate_reg > rate_steps_high_reg[31:0])
            ladder_pick = batch_sizes_reg[4*SIZE_W +: SIZE_W];
        else if (ladder_rate_reg > rate_steps_low_reg[63:32])
            ladder_pick = batch_sizes_reg[3*SIZE_W +: SIZE_W];
        else if (ladder_rate_reg > rate_steps_low_reg[31:0])
            ladder_pick = batch_sizes_reg[2*SIZE_W +: SIZE_W];
        else
            ladder_pick = batch_sizes_reg[1*SIZE_W +: SIZE_W];

        // floor size applies above the floor rate
        if (ladder_rate_reg > rate_steps_high_reg[63:32] && ladder_pick < size_floor)
            ladder_size = size_floor;
        else
            ladder_size = ladder_pick;
    end

    // ---------------- sequencer ----------------
    assign item.ready    = (state_reg == S_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        pkt_total_next    = pkt_total_reg;
        tot_capt_next     = tot_capt_reg;
        last_tick_next    = last_tick_reg;
        capt_tick_next    = capt_tick_reg;
        created_tick_next = created_tick_reg;
        interval_next     = interval_reg;
        stored_rate_next  = stored_rate_reg;
        mode_next         = mode_reg;
        size_next         = size_reg;
        ladder_rate_next  = ladder_rate_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_size_next     = out_size_reg;
        out_mode_next     = out_mode_reg;
        out_rate_next     = out_rate_reg;
        div_req.start     = 1'b0;
        div_req.pkts      = pkt_total_reg - tot_capt_reg;
        div_req.ticks     = last_tick_reg - capt_tick_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    if (!item.kind)
                    begin
                        // new flow: clear counters, stamp creation time
                        created_tick_next = item.now;
                        last_tick_next    = item.now;
                        capt_tick_next    = item.now;
                        interval_next     = phase_intervals_reg[31:0];
                        mode_next         = MODE_NONE;
                        pkt_total_next    = '0;
                        tot_capt_next     = '0;
                        stored_rate_next  = '0;
                        size_next         = '0;
                        state_next        = S_EMIT;
                    end
                    else
                    begin
                        pkt_total_next = pkt_total_reg + 1'b1;
                        last_tick_next = item.now;
                        state_next     = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                if (is_after(last_tick_reg, capt_tick_reg + interval_reg) ||
                    mode_reg != MODE_FLEX)
                begin
                    if (mode_reg == MODE_FLEX)
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_MEAS_WAIT;
                    end
                    else
                    begin
                        state_next = S_POLICY;
                    end
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_MEAS_WAIT:
            begin
                if (div_rsp.done)
                begin
                    stored_rate_next = div_rsp.quot;
                    capt_tick_next   = last_tick_reg;
                    tot_capt_next    = pkt_total_reg;
                    // old flow switches to the later update interval
                    if (is_after(last_tick_reg, created_tick_reg + phase_threshold_reg))
                        interval_next = phase_intervals_reg[63:32];
                    state_next = S_POLICY;
                end
            end
            S_POLICY:
            begin
                if (pkt_total_reg == fixed_count_reg)
                begin
                    size_next  = batch_sizes_reg[0 +: SIZE_W];
                    mode_next  = MODE_FIXED;
                    state_next = S_EMIT;
                end
                else if (pkt_total_reg == flex_count_reg)
                begin
                    // local rate for this step only, not stored
                    div_req.start = 1'b1;
                    state_next    = S_FLEX_WAIT;
                end
                else if (mode_reg == MODE_FLEX)
                begin
                    ladder_rate_next = stored_rate_reg;
                    state_next       = S_LADDER;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_FLEX_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ladder_rate_next = div_rsp.quot;
                    mode_next        = MODE_FLEX;
                    state_next       = S_LADDER;
                end
            end
            S_LADDER:
            begin
                size_next  = ladder_size;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_size_next  = size_reg;
                    out_mode_next  = mode_reg;
                    out_rate_next  = stored_rate_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pkt_total_reg    <= '0;
            tot_capt_reg     <= '0;
            last_tick_reg    <= '0;
            capt_tick_reg    <= '0;
            created_tick_reg <= '0;
            interval_reg     <= '0;
            stored_rate_reg  <= '0;
            mode_reg         <= MODE_NONE;
            size_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pkt_total_reg    <= pkt_total_next;
            tot_capt_reg     <= tot_capt_next;
            last_tick_reg    <= last_tick_next;
            capt_tick_reg    <= capt_tick_next;
            created_tick_reg <= created_tick_next;
            interval_reg     <= interval_next;
            stored_rate_reg  <= stored_rate_next;
            mode_reg         <= mode_next;
            size_reg         <= size_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        ladder_rate_reg <= ladder_rate_next;
        out_size_reg    <= out_size_next;
        out_mode_reg    <= out_mode_next;
        out_rate_reg    <= out_rate_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.batch_size = out_size_reg;
    assign result.mode       = out_mode_reg;
    assign result.rate       = out_rate_reg;

endmodule

FILE: dv/flow_batch_size_policy_tb.sv
// Self-checking testbench for flow_batch_size_policy: directed and random flows over
// several register settings and handshake idling patterns.
// Depends on fbsp_pkg and the fbsp_item_if / fbsp_result_if channel interfaces.
`timescale 1ns / 1ps

module flow_batch_size_policy_tb;
    import fbsp_pkg::*;

    localparam int LIMIT_CYCLES   = 1_500_000;
    localparam int SETTLE_CYCLES  = 80;    // two rate divisions plus pipeline
    localparam int PHASE_REQUESTS = 225;   // random requests per setting

    // idling patterns
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_SENDER = 1;
    localparam int IDLE_RECV   = 2;
    localparam int IDLE_BOTH   = 3;

    // request kinds
    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_PACKET = 1'b1;

    typedef struct {
        logic        kind;
        logic [31:0] now;
        bit          drain;    // hold this request until every decision is back
    } flow_req_t;

    typedef struct packed {
        logic [7:0]  batch_size;
        mode_t       mode;
        logic [31:0] rate;
    } decision_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    fbsp_item_if   item_ch ();
    fbsp_result_if result_ch ();

    flow_batch_size_policy DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    // ------------------------------------------------------------------
    // Policy predictor: register copies and the flow state
    // ------------------------------------------------------------------
    logic [31:0] cfg_fixed_count;
    logic [31:0] cfg_flex_count;
    logic [47:0] cfg_sizes;        // fixed, step0..step3, floor from byte 0 up
    logic [63:0] cfg_steps_lo;     // step0 bound [31:0], step1 bound [63:32]
    logic [63:0] cfg_steps_hi;     // step2 bound [31:0], floor rate [63:32]
    logic [31:0] cfg_threshold;
    logic [63:0] cfg_intervals;    // initial [31:0], later [63:32]

    logic [31:0] pkt_total;
    logic [31:0] pkt_at_capture;
    logic [31:0] last_tk;
    logic [31:0] capture_tk;
    logic [31:0] created_tk;
    logic [31:0] interval_tk;
    logic [31:0] rate_q;
    mode_t       cur_mode;
    logic [7:0]  cur_size;

    flow_req_t req_queue[$];
    decision_t pending_decisions[$];

    int idle_mode;
    int calm_left;
    int cycle_count;
    int n_queued;
    int n_accepted;
    int n_results;
    int n_fail;
    int n_phases;
    int n_rate_updates;
    int n_saturated;
    int n_fixed_seen;
    int n_flex_seen;

    // wrap-safe "a lies strictly after b"
    function automatic logic tick_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && (d < 32'h8000_0000);
    endfunction

    // packets since capture, scaled to ticks per second; saturates
    function automatic logic [31:0] measured_rate();
        logic [31:0] pkts;
        logic [31:0] ticks;
        logic [63:0] q;
        pkts  = pkt_total - pkt_at_capture;
        ticks = last_tk - capture_tk;
        if (ticks == 32'd0) begin
            n_saturated++;
            return '1;
        end
        q = (64'(pkts) * 64'(TICKS_PER_SECOND)) / 64'(ticks);
        if (q[63:32] != 32'd0) begin
            n_saturated++;
            return '1;
        end
        return q[31:0];
    endfunction

    function automatic void apply_size_policy(input logic [31:0] r_in);
        logic [31:0] r;
        r = r_in;
        // fixed count is checked first, so it wins when both counts match
        if (pkt_total == cfg_fixed_count) begin
            cur_size = cfg_sizes[7:0];
            cur_mode = MODE_FIXED;
            return;
        end
        // flex entry uses a fresh local rate that is not stored
        if (pkt_total == cfg_flex_count) begin
            r        = measured_rate();
            cur_mode = MODE_FLEX;
        end
        if (cur_mode != MODE_FLEX)
            return;
        if (r > cfg_steps_hi[31:0])
            cur_size = cfg_sizes[39:32];
        else if (r > cfg_steps_lo[63:32])
            cur_size = cfg_sizes[31:24];
        else if (r > cfg_steps_lo[31:0])
            cur_size = cfg_sizes[23:16];
        else
            cur_size = cfg_sizes[15:8];
        if (r > cfg_steps_hi[63:32] && cur_size < cfg_sizes[47:40])
            cur_size = cfg_sizes[47:40];
    endfunction

    function automatic decision_t next_policy(input logic kind, input logic [31:0] now);
        decision_t d;
        if (kind == KIND_START) begin
            created_tk     = now;
            last_tk        = now;
            capture_tk     = now;
            interval_tk    = cfg_intervals[31:0];
            cur_mode       = MODE_NONE;
            pkt_total      = '0;
            pkt_at_capture = '0;
            rate_q         = '0;
            cur_size       = '0;
        end
        else begin
            pkt_total = pkt_total + 32'd1;
            last_tk   = now;
            if (tick_after(last_tk, capture_tk + interval_tk) || cur_mode != MODE_FLEX) begin
                if (cur_mode == MODE_FLEX) begin
                    rate_q         = measured_rate();
                    capture_tk     = last_tk;
                    pkt_at_capture = pkt_total;
                    n_rate_updates++;
                    if (tick_after(last_tk, created_tk + cfg_threshold))
                        interval_tk = cfg_intervals[63:32];
                end
                apply_size_policy(rate_q);
            end
        end
        d.batch_size = cur_size;
        d.mode       = cur_mode;
        d.rate       = rate_q;
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit, calm stretches
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles, %0d decisions still pending",
                     cycle_count, pending_decisions.size());
            $display("== FAIL ==");
            $finish;
        end
        // now and then both sides run flat out for a while
        if (calm_left > 0)
            calm_left <= calm_left - 1;
        else if ($urandom_range(99) == 0)
            calm_left <= $urandom_range(60, 20);
    end

    function automatic bit roll_gap(input int pct);
        return (calm_left == 0) && ($urandom_range(99) < pct);
    endfunction

    function automatic int sender_pct();
        return (idle_mode == IDLE_SENDER) ? 67 : (idle_mode == IDLE_BOTH) ? 31 : 0;
    endfunction

    function automatic int recv_pct();
        return (idle_mode == IDLE_RECV) ? 67 : (idle_mode == IDLE_BOTH) ? 31 : 0;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: predicts on acceptance, then offers the next request
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        flow_req_t nxt;
        if (rst_n) begin
            if (item_ch.valid && item_ch.ready) begin
                pending_decisions.push_back(next_policy(item_ch.kind, item_ch.now));
                n_accepted++;
            end
            // valid holds until the block takes the request
            if (!item_ch.valid || item_ch.ready) begin
                if (req_queue.size() > 0 && !roll_gap(sender_pct()) &&
                    (!req_queue[0].drain || pending_decisions.size() == 0)) begin
                    nxt = req_queue.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.kind  <= nxt.kind;
                    item_ch.now   <= nxt.now;
                end
                else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compares against the oldest predicted decision
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        decision_t want;
        if (rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                n_results++;
                if (pending_decisions.size() == 0) begin
                    $error("result with no request outstanding: size %0d mode %0d rate %0d",
                           result_ch.batch_size, result_ch.mode, result_ch.rate);
                    n_fail++;
                end
                else begin
                    want = pending_decisions.pop_front();
                    if (result_ch.batch_size !== want.batch_size) begin
                        $error("batch_size mismatch: expected %0d, got %0d",
                               want.batch_size, result_ch.batch_size);
                        n_fail++;
                    end
                    if (result_ch.mode !== want.mode) begin
                        $error("mode mismatch: expected %0d, got %0d",
                               want.mode, result_ch.mode);
                        n_fail++;
                    end
                    if (result_ch.rate !== want.rate) begin
                        $error("rate mismatch: expected %0d, got %0d",
                               want.rate, result_ch.rate);
                        n_fail++;
                    end
                    if (want.mode == MODE_FIXED)
                        n_fixed_seen++;
                    if (want.mode == MODE_FLEX)
                        n_flex_seen++;
                end
            end
            result_ch.ready <= !roll_gap(recv_pct());
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        logic [63:0] rd_want;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);    // register takes the data at this edge
        if (pready !== 1'b1) begin
            $error("pready mismatch: expected 1, got %0b", pready);
            n_fail++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rd_want = '0;
        case (idx)
            REG_FIXED_COUNT:
            begin
                cfg_fixed_count = val[31:0];
                rd_want         = 64'(val[31:0]);
            end
            REG_FLEX_COUNT:
            begin
                cfg_flex_count = val[31:0];
                rd_want        = 64'(val[31:0]);
            end
            REG_BATCH_SIZES:
            begin
                cfg_sizes = val[47:0];
                rd_want   = 64'(val[47:0]);
            end
            REG_RATE_STEPS_LOW:
            begin
                cfg_steps_lo = val;
                rd_want      = val;
            end
            REG_RATE_STEPS_HIGH:
            begin
                cfg_steps_hi = val;
                rd_want      = val;
            end
            REG_PHASE_THRESHOLD:
            begin
                cfg_threshold = val[31:0];
                rd_want       = 64'(val[31:0]);
            end
            REG_PHASE_INTERVALS:
            begin
                cfg_intervals = val;
                rd_want       = val;
            end
            default: ;
        endcase
        // read back while paddr still points at the register
        @(posedge clk);
        if (prdata !== rd_want) begin
            $error("prdata mismatch: expected %0h, got %0h", rd_want, prdata);
            n_fail++;
        end
    endtask

    task automatic write_all(input logic [31:0] fixed_c, input logic [31:0] flex_c,
                             input logic [47:0] sizes, input logic [63:0] steps_lo,
                             input logic [63:0] steps_hi, input logic [31:0] thresh,
                             input logic [63:0] intervals);
        reg_write(REG_FIXED_COUNT, 64'(fixed_c));
        reg_write(REG_FLEX_COUNT, 64'(flex_c));
        reg_write(REG_BATCH_SIZES, 64'(sizes));
        reg_write(REG_RATE_STEPS_LOW, steps_lo);
        reg_write(REG_RATE_STEPS_HIGH, steps_hi);
        reg_write(REG_PHASE_THRESHOLD, 64'(thresh));
        reg_write(REG_PHASE_INTERVALS, intervals);
        n_phases++;
    endtask

    task automatic add_req(input logic kind, input logic [31:0] now, input bit drain);
        flow_req_t r;
        r.kind  = kind;
        r.now   = now;
        r.drain = drain;
        req_queue.push_back(r);
        n_queued++;
    endtask

    // every request sent, every decision back, then let the divider settle
    task automatic wait_quiet();
        while (req_queue.size() != 0 || n_accepted != n_queued ||
               pending_decisions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly short steps; sometimes a burst in one tick or a far jump
    function automatic logic [31:0] tick_gap(input int scale);
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return 32'd0;
        if (roll < 12)
            return $urandom;
        if (roll < 20)
            return $urandom_range(300);
        return $urandom_range(scale);
    endfunction

    // one well-formed flow: a start, then a run of packets
    task automatic queue_flow(input bit drain, inout int budget);
        logic [31:0] t;
        int          n;
        int          scale;
        t = $urandom;
        n = ($urandom_range(9) == 0) ? $urandom_range(80, 41) : $urandom_range(40, 1);
        case ($urandom_range(3))
            0:       scale = 1;
            1:       scale = 4;
            2:       scale = 12;
            default: scale = 40;
        endcase
        add_req(KIND_START, t, drain);
        budget--;
        for (int i = 0; i < n && budget > 0; i++) begin
            t = t + tick_gap(scale);
            add_req(KIND_PACKET, t, 1'b0);
            budget--;
        end
    endtask

    task automatic random_settings(input int style);
        logic [31:0] fc;
        logic [31:0] xc;
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] fl;
        if (style == 0) begin
            write_all('0, '0, '0, '0, '0, '0, '0);
        end
        else if (style == 1) begin
            write_all('1, '1, '1, '1, '1, '1, '1);
        end
        else begin
            fc = ($urandom_range(7) == 0) ? $urandom : $urandom_range(12);
            xc = ($urandom_range(7) == 0) ? fc : $urandom_range(12);
            s0 = $urandom_range(60);
            s1 = s0 + $urandom_range(150);
            s2 = s1 + $urandom_range(400);
            fl = $urandom_range(600);
            if ($urandom_range(5) == 0) begin
                s1 = $urandom;
                fl = $urandom;
            end
            write_all(fc, xc, {16'($urandom), 32'($urandom)}, {s1, s0}, {fl, s2},
                      $urandom_range(200),
                      {32'($urandom_range(60)), 32'($urandom_range(30))});
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int budget;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        item_ch.valid     = 1'b0;
        item_ch.kind      = KIND_START;
        item_ch.now       = '0;
        result_ch.ready   = 1'b0;
        idle_mode         = IDLE_NONE;
        calm_left         = 0;
        cycle_count       = 0;
        n_queued          = 0;
        n_accepted        = 0;
        n_results         = 0;
        n_fail            = 0;
        n_phases          = 0;
        n_rate_updates    = 0;
        n_saturated       = 0;
        n_fixed_seen      = 0;
        n_flex_seen       = 0;
        cfg_fixed_count   = '0;
        cfg_flex_count    = '0;
        cfg_sizes         = '0;
        cfg_steps_lo      = '0;
        cfg_steps_hi      = '0;
        cfg_threshold     = '0;
        cfg_intervals     = '0;
        pkt_total         = '0;
        pkt_at_capture    = '0;
        last_tk           = '0;
        capture_tk        = '0;
        created_tk        = '0;
        interval_tk       = '0;
        rate_q            = '0;
        cur_mode          = MODE_NONE;
        cur_size          = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Packets before any start act on the reset flow; start at the top
        // of the tick range, then a packet that wraps to zero.
        add_req(KIND_PACKET, 32'd0, 1'b0);
        add_req(KIND_PACKET, 32'hFFFF_FFFF, 1'b0);
        add_req(KIND_START, 32'hFFFF_FFFF, 1'b0);
        add_req(KIND_PACKET, 32'd0, 1'b0);
        wait_quiet();

        // Fixed at count 2, flexible at count 4; the flow straddles the wrap,
        // crosses the age threshold and takes a step backward in time.
        write_all(32'd2, 32'd4, 48'h28_20_10_08_04_02, {32'd200, 32'd50},
                  {32'd500, 32'd1000}, 32'd30, {32'd20, 32'd5});
        add_req(KIND_START, 32'hFFFF_FFF0, 1'b0);
        add_req(KIND_PACKET, 32'hFFFF_FFF1, 1'b0);
        add_req(KIND_PACKET, 32'hFFFF_FFF2, 1'b0);
        add_req(KIND_PACKET, 32'hFFFF_FFF3, 1'b0);
        add_req(KIND_PACKET, 32'hFFFF_FFF3, 1'b0);
        add_req(KIND_PACKET, 32'hFFFF_FFFA, 1'b0);
        add_req(KIND_PACKET, 32'hFFFF_FFFC, 1'b0);
        add_req(KIND_PACKET, 32'h0000_0000, 1'b0);
        add_req(KIND_PACKET, 32'h8000_0000, 1'b0);
        add_req(KIND_PACKET, 32'h0000_0020, 1'b0);
        add_req(KIND_PACKET, 32'h0000_0021, 1'b0);
        wait_quiet();

        // Flex entry with zero elapsed ticks saturates the rate; the floor
        // size then lifts the ladder pick. Fixed takes over later.
        write_all(32'd5, 32'd1, 48'h80_FF_C0_40_01_FF, {32'hFFFF_FFFF, 32'd0},
                  {32'd0, 32'hFFFF_FFFF}, 32'd0, {32'd0, 32'd0});
        add_req(KIND_START, 32'd100, 1'b0);
        add_req(KIND_PACKET, 32'd100, 1'b0);
        add_req(KIND_PACKET, 32'd101, 1'b0);
        add_req(KIND_PACKET, 32'd103, 1'b0);
        add_req(KIND_PACKET, 32'd103, 1'b0);
        add_req(KIND_PACKET, 32'd110, 1'b0);
        wait_quiet();

        // Both counts equal: fixed must win.
        reg_write(REG_FLEX_COUNT, 64'd2);
        reg_write(REG_FIXED_COUNT, 64'd2);
        add_req(KIND_START, 32'd0, 1'b0);
        add_req(KIND_PACKET, 32'd7, 1'b0);
        add_req(KIND_PACKET, 32'd9, 1'b0);
        wait_quiet();

        // Random flows across settings and idling patterns; the first flow of
        // each setting waits for the block to drain completely.
        for (int k = 0; k < 8; k++) begin
            random_settings((k == 2) ? 0 : (k == 5) ? 1 : 2);
            idle_mode = k % 4;
            budget = PHASE_REQUESTS;
            queue_flow(1'b1, budget);
            while (budget > 0) begin
                if ($urandom_range(9) == 0) begin
                    add_req(1'($urandom_range(1)), $urandom, 1'b0);
                    budget--;
                end
                else begin
                    queue_flow($urandom_range(19) == 0, budget);
                end
            end
            wait_quiet();
        end

        $display("Ran %0d requests, checked %0d decisions over %0d register settings;",
                 n_accepted, n_results, n_phases);
        $display("%0d fixed-mode, %0d flexible-mode, %0d rate updates, %0d saturated rates.",
                 n_fixed_seen, n_flex_seen, n_rate_updates, n_saturated);
        if (n_fail == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
